// ===== rtl/mhpq_pkg.sv =====
`default_nettype none

package mhpq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL_INSERT = 2'd1,
    ST_EMPTY_REMOVE = 2'd2
  } status_e_t;

  // Contents of one cell as seen by its neighbours
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
  } cell_link_t;

  // Broadcast to every cell for the transaction in hand
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_op_t;

endpackage

`default_nettype wire

// ===== rtl/mhpq_if.sv =====
`default_nettype none

interface mhpq_req_if
  import mhpq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  cmd_e_t                   command;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface mhpq_rsp_if
  import mhpq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  removed_value;
  status_e_t                 status;
  logic signed [DATA_W-1:0]  min_value;
  logic [COUNT_W-1:0]        count;
  logic                      is_full;
  logic                      is_empty;

  modport source (output valid, output removed_value, output status, output min_value,
                  output count, output is_full, output is_empty, input ready);
  modport sink   (input valid, input removed_value, input status, input min_value,
                  input count, input is_full, input is_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/min_heap_priority_queue_unit.sv =====
`default_nettype none

// The result of an accepted transaction is registered onto the response channel.
// Throughput: one transaction per cycle unless the response side stalls; every
// cell of the sorted row updates in one step (shift in on insert, shift out on
// remove), so no walk over levels. A result waiting in the output register does
// not block the next transaction unless the response side is stalled.
// Reset (synchronous, active high) empties the queue and drops any pending result.

module min_heap_priority_queue_unit
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  mhpq_req_if.sink   request,
  mhpq_rsp_if.source response
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

  cell_link_t links    [CAPACITY];
  logic       ins_flag [CAPACITY];
  cell_op_t   op;

  logic [CW-1:0] occ;
  logic [CW-1:0] occ_next;
  logic          full;
  logic          empty;
  logic          accept;

  logic                     out_valid;
  logic signed [DATA_W-1:0] removed_next;
  logic signed [DATA_W-1:0] min_next;
  status_e_t                status_next;
  logic [CW+COUNT_W-1:0]    occ_ext;

  assign full   = (occ == CAP_W);
  assign empty  = (occ == '0);
  assign accept = request.valid && request.ready;

  assign request.ready = !out_valid || response.ready;

  assign op.ins   = accept && (request.command == CMD_INSERT) && !full;
  assign op.rem   = accept && (request.command == CMD_REMOVE) && !empty;
  assign op.value = request.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left_l;
    cell_link_t right_l;
    logic       left_i;

    if (i == 0) begin : g_head
      assign left_l = '{valid: 1'b1, data: '0};
      assign left_i = 1'b0;
    end else begin : g_body
      assign left_l = links[i-1];
      assign left_i = ins_flag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_l = '{valid: 1'b0, data: '0};
    end else begin : g_more
      assign right_l = links[i+1];
    end

    mhpq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .left_link  (left_l),
      .left_ins   (left_i),
      .right_link (right_l),
      .link       (links[i]),
      .ins_here   (ins_flag[i])
    );
  end

  always_comb begin
    occ_next     = occ;
    removed_next = '0;
    status_next  = ST_OK;
    min_next     = empty ? '0 : links[0].data;
    unique case (request.command)
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL_INSERT;
        end else begin
          occ_next = occ + 1'b1;
          if (empty || (request.value < links[0].data)) begin
            min_next = request.value;
          end
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          status_next = ST_EMPTY_REMOVE;
        end else begin
          occ_next     = occ - 1'b1;
          removed_next = links[0].data;
          min_next     = links[1].valid ? links[1].data : '0;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  assign occ_ext = {{COUNT_W{1'b0}}, occ_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        occ       <= occ_next;
        out_valid <= 1'b1;
      end else if (response.ready) begin
        // drop the result once taken
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      response.removed_value <= removed_next;
      response.status        <= status_next;
      response.min_value     <= min_next;
      response.count         <= occ_ext[COUNT_W-1:0];
      response.is_full       <= (occ_next == CAP_W);
      response.is_empty      <= (occ_next == '0);
    end
  end

  assign response.valid = out_valid;

endmodule

`default_nettype wire

// ===== rtl/mhpq_cell.sv =====
`default_nettype none

module mhpq_cell
  import mhpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_op_t   op,
  input  wire cell_link_t left_link,
  input  wire logic       left_ins,
  input  wire cell_link_t right_link,
  output      cell_link_t link,
  output      logic       ins_here
);

  logic                     valid;
  logic signed [DATA_W-1:0] data;

  // The row stays sorted, so this flag rises once and stays high to the right
  assign ins_here = !valid || (data > op.value);

  assign link.valid = valid;
  assign link.data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.rem) begin
      valid <= right_link.valid;
    end else if (op.ins) begin
      if (left_ins) begin
        valid <= left_link.valid;
      end else if (ins_here) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.rem) begin
      data <= right_link.data;
    end else if (op.ins) begin
      if (left_ins) begin
        data <= left_link.data;
      end else if (ins_here) begin
        data <= op.value;
      end
    end
  end

endmodule

`default_nettype wire
